>>> src/transaction_duration_extractor_assert.svh
// Assertion macros for the duration extractor RTL.
// Used by modules that check their own control logic; needs clk and rst_n in scope.
`ifndef TRANSACTION_DURATION_EXTRACTOR_ASSERT_SVH
`define TRANSACTION_DURATION_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define TDE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tde assertion failed");

// next-cycle implication
`define TDE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tde assertion failed");

`endif

>>> src/tde_pkg.sv
// Shared types, constants and helpers for the transaction duration extractor.
// No dependencies.
package tde_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [15:0] COUNT_MAX = 16'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [31:0] MS_PER_HOUR   = 32'd3600000;
    localparam logic [31:0] MS_PER_MINUTE = 32'd60000;

    localparam logic [26:0] OPEN_RESET  = 27'd34200000;
    localparam logic [26:0] CLOSE_RESET = 27'd57600000;

    typedef enum logic [2:0] {
        CFG_KIND   = 3'd0,
        CFG_MERGE  = 3'd1,
        CFG_OPEN   = 3'd2,
        CFG_CLOSE  = 3'd3,
        CFG_PTHR   = 3'd4,
        CFG_VTHR   = 3'd5
    } cfg_reg_t;

    localparam logic [1:0] KIND_TRADE  = 2'd0;
    localparam logic [1:0] KIND_PRICE  = 2'd1;
    localparam logic [1:0] KIND_VOLUME = 2'd2;

    localparam logic [1:0] PH_NONE    = 2'd0;
    localparam logic [1:0] PH_WAIT    = 2'd1;
    localparam logic [1:0] PH_OPENREF = 2'd2;
    localparam logic [1:0] PH_RUN     = 2'd3;

    typedef struct packed {
        logic [20:0] date;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] second_ms;
        logic [26:0] t;
        logic [30:0] volume;
        logic [31:0] price;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [20:0] date;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] second_ms;
        logic [31:0] volume;
        logic [31:0] price;
        logic [26:0] dur;
        logic [15:0] count;
        logic [31:0] row_number;
        logic        last;
    } row_t;

    function automatic logic [26:0] dur_of(logic [26:0] t, logic [26:0] base);
        return (t >= base) ? (t - base) : 27'd0;
    endfunction

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [63:0] sat_add64(logic [63:0] a, logic [62:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {2'b00, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [15:0] sat_inc(logic [15:0] c);
        return (c < COUNT_MAX) ? (c + 16'd1) : c;
    endfunction

endpackage

>>> src/tde_front.sv
// Front end: input word register, time-of-day and date packing, two-word queue.
// Depends on tde_pkg.
module tde_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [11:0]   year,
    input  logic [3:0]    month,
    input  logic [4:0]    day,
    input  logic [4:0]    hour,
    input  logic [5:0]    minute,
    input  logic [15:0]   second_ms,
    input  logic [30:0]   volume,
    input  logic [31:0]   price,
    input  logic          last_item,
    output logic          item_valid,
    output tde_pkg::item_t item,
    input  logic          item_pop
);

    logic            s1_valid_reg, s1_valid_next;
    tde_pkg::item_t  s1_reg, s1_next;
    tde_pkg::item_t  q_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            accept, move, do_pop;
    tde_pkg::item_t  cooked;

    assign full   = s1_valid_reg && (count_reg == 2'd2);
    assign accept = push && !full;
    assign move   = s1_valid_reg && (count_reg != 2'd2);
    assign do_pop = item_pop && (count_reg != 2'd0);

    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        s1_next           = s1_reg;
        s1_next.date      = {year, month, day};
        s1_next.hour      = hour;
        s1_next.minute    = minute;
        s1_next.second_ms = second_ms;
        s1_next.t         = '0;
        s1_next.volume    = volume;
        s1_next.price     = price;
        s1_next.last      = last_item;

        cooked   = s1_reg;
        cooked.t = 27'(32'(s1_reg.hour) * tde_pkg::MS_PER_HOUR
                     + 32'(s1_reg.minute) * tde_pkg::MS_PER_MINUTE
                     + 32'(s1_reg.second_ms));

        s1_valid_next = accept ? 1'b1 : (move ? 1'b0 : s1_valid_reg);
        wr_ptr_next   = move ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next    = count_reg + 2'(move) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (move)
        begin
            q_reg[wr_ptr_reg] <= cooked;
        end
    end

endmodule

>>> src/tde_row_fifo.sv
// Four-word result queue between the back end and the result ports.
// Depends on tde_pkg.
module tde_row_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tde_pkg::row_t wr_row,
    input  logic          pop,
    output logic          empty,
    output tde_pkg::row_t head,
    output logic [2:0]    count
);

    tde_pkg::row_t mem_reg [4];
    logic [1:0]    wr_ptr_reg, wr_ptr_next;
    logic [1:0]    rd_ptr_reg, rd_ptr_next;
    logic [2:0]    count_reg, count_next;
    logic          do_pop;

    assign empty  = (count_reg == 3'd0);
    assign head   = mem_reg[rd_ptr_reg];
    assign count  = count_reg;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + 3'(wr_en) - 3'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_row;
        end
    end

endmodule

>>> src/tde_back.sv
// Back end: day/window tracking, accumulation, duration decisions, bit-serial
// divider for merged prices, config registers. Depends on tde_pkg and the assert header.
`include "transaction_duration_extractor_assert.svh"

module tde_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    input  logic           item_valid,
    input  tde_pkg::item_t item,
    output logic           item_pop,
    output logic           row_push,
    output tde_pkg::row_t  row_data,
    input  logic [2:0]     row_count
);

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_FLUSH, S_DIV, S_FEMIT, S_BODY, S_LAST, S_DONE
    } state_t;

    state_t          state_reg, state_next;

    logic [1:0]      kind_reg;
    logic            merge_reg;
    logic [26:0]     open_reg, close_reg;
    logic [31:0]     pthr_reg, vthr_reg;

    tde_pkg::item_t  it_reg, it_next;
    logic [62:0]     prod_reg, prod_next;
    logic            newday_reg, newday_next;
    logic            joins_reg, joins_next;
    logic            ret_done_reg, ret_done_next;

    logic [20:0]     cd_reg, cd_next;
    logic [1:0]      ph_reg, ph_next;
    logic [26:0]     rt_reg, rt_next;
    logic [31:0]     rp_reg, rp_next;
    logic [31:0]     cv_reg, cv_next;
    logic [63:0]     ts_reg, ts_next;
    logic [15:0]     gc_reg, gc_next;
    logic [31:0]     rc_reg, rc_next;

    logic            pend_valid_reg, pend_valid_next;
    logic [4:0]      pend_hour_reg, pend_hour_next;
    logic [5:0]      pend_minute_reg, pend_minute_next;
    logic [15:0]     pend_sec_reg, pend_sec_next;
    logic [26:0]     pend_t_reg, pend_t_next;
    logic [31:0]     pend_price_reg, pend_price_next;

    logic [31:0]     rem_reg, rem_next;
    logic [63:0]     quo_reg, quo_next;
    logic [5:0]      divcnt_reg, divcnt_next;
    logic            divused_reg, divused_next;

    logic            held_valid_reg, held_valid_next;
    tde_pkg::row_t   held_reg, held_next;

    logic            emit_en;
    tde_pkg::row_t   emit_row;
    logic            trade_win, in_win, hit;
    logic [32:0]     rem_shift;
    logic [31:0]     diff;

    always_comb
    begin
        state_next       = state_reg;
        it_next          = it_reg;
        prod_next        = prod_reg;
        newday_next      = newday_reg;
        joins_next       = joins_reg;
        ret_done_next    = ret_done_reg;
        cd_next          = cd_reg;
        ph_next          = ph_reg;
        rt_next          = rt_reg;
        rp_next          = rp_reg;
        cv_next          = cv_reg;
        ts_next          = ts_reg;
        gc_next          = gc_reg;
        rc_next          = rc_reg;
        pend_valid_next  = pend_valid_reg;
        pend_hour_next   = pend_hour_reg;
        pend_minute_next = pend_minute_reg;
        pend_sec_next    = pend_sec_reg;
        pend_t_next      = pend_t_reg;
        pend_price_next  = pend_price_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        divcnt_next      = divcnt_reg;
        divused_next     = divused_reg;
        held_valid_next  = held_valid_reg;
        held_next        = held_reg;
        item_pop         = 1'b0;
        row_push         = 1'b0;
        row_data         = held_reg;
        emit_en          = 1'b0;
        emit_row         = '0;
        hit              = 1'b0;
        trade_win = (it_reg.t > open_reg) && (it_reg.t <= close_reg);
        in_win    = (it_reg.t >= open_reg) && (it_reg.t <= close_reg);
        rem_shift = {rem_reg, quo_reg[63]};
        diff      = (it_reg.price >= rp_reg) ? it_reg.price - rp_reg : rp_reg - it_reg.price;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && (row_count <= 3'd2))
                begin
                    item_pop   = 1'b1;
                    it_next    = item;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                newday_next = (ph_reg == tde_pkg::PH_NONE) || (it_reg.date != cd_reg);
                joins_next  = pend_valid_reg && !newday_next
                              && (kind_reg == tde_pkg::KIND_TRADE) && merge_reg
                              && trade_win && (it_reg.t == pend_t_reg);
                prod_next   = 63'(it_reg.volume) * 63'(it_reg.price);
                if (pend_valid_reg && !joins_next)
                begin
                    ret_done_next = 1'b0;
                    state_next    = S_FLUSH;
                end
                else
                begin
                    state_next = S_BODY;
                end
            end
            S_FLUSH:
            begin
                if ((gc_reg > 16'd1) && (cv_reg != 32'd0))
                begin
                    rem_next     = '0;
                    quo_next     = ts_reg;
                    divcnt_next  = '0;
                    divused_next = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    divused_next = 1'b0;
                    state_next   = S_FEMIT;
                end
            end
            S_DIV:
            begin
                if (rem_shift >= {1'b0, cv_reg})
                begin
                    rem_next = 32'(rem_shift - {1'b0, cv_reg});
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[31:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                divcnt_next = divcnt_reg + 6'd1;
                if (divcnt_reg == 6'd63)
                begin
                    state_next = S_FEMIT;
                end
            end
            S_FEMIT:
            begin
                emit_en             = 1'b1;
                emit_row.date       = cd_reg;
                emit_row.hour       = pend_hour_reg;
                emit_row.minute     = pend_minute_reg;
                emit_row.second_ms  = pend_sec_reg;
                emit_row.volume     = cv_reg;
                if (!divused_reg)
                    emit_row.price  = pend_price_reg;
                else if (quo_reg[63:32] != 32'd0)
                    emit_row.price  = 32'hFFFF_FFFF;
                else
                    emit_row.price  = quo_reg[31:0];
                emit_row.dur        = tde_pkg::dur_of(pend_t_reg, rt_reg);
                emit_row.count      = gc_reg;
                emit_row.row_number = rc_reg;
                rc_next         = rc_reg + 32'd1;
                rt_next         = pend_t_reg;
                cv_next         = '0;
                ts_next         = '0;
                gc_next         = '0;
                pend_valid_next = 1'b0;
                state_next      = ret_done_reg ? S_DONE : S_BODY;
            end
            S_BODY:
            begin
                if (newday_reg)
                begin
                    cd_next = it_reg.date;
                    ph_next = tde_pkg::PH_WAIT;
                    rt_next = open_reg;
                    rp_next = '0;
                    cv_next = '0;
                    ts_next = '0;
                    gc_next = '0;
                end
                if (kind_reg == tde_pkg::KIND_TRADE)
                begin
                    if (trade_win)
                    begin
                        if (!merge_reg)
                        begin
                            emit_en             = 1'b1;
                            emit_row.date       = cd_next;
                            emit_row.hour       = it_reg.hour;
                            emit_row.minute     = it_reg.minute;
                            emit_row.second_ms  = it_reg.second_ms;
                            emit_row.volume     = {1'b0, it_reg.volume};
                            emit_row.price      = it_reg.price;
                            emit_row.dur        = tde_pkg::dur_of(it_reg.t, rt_next);
                            emit_row.count      = 16'd1;
                            emit_row.row_number = rc_reg;
                            rc_next = rc_reg + 32'd1;
                            rt_next = it_reg.t;
                        end
                        else
                        begin
                            if (!joins_reg)
                            begin
                                cv_next          = '0;
                                ts_next          = '0;
                                gc_next          = '0;
                                pend_valid_next  = 1'b1;
                                pend_hour_next   = it_reg.hour;
                                pend_minute_next = it_reg.minute;
                                pend_sec_next    = it_reg.second_ms;
                                pend_t_next      = it_reg.t;
                            end
                            ts_next         = tde_pkg::sat_add64(ts_next, prod_reg);
                            cv_next         = tde_pkg::sat_add32(cv_next, {1'b0, it_reg.volume});
                            gc_next         = tde_pkg::sat_inc(gc_next);
                            pend_price_next = it_reg.price;
                        end
                    end
                end
                else if ((kind_reg == tde_pkg::KIND_PRICE) || (kind_reg == tde_pkg::KIND_VOLUME))
                begin
                    if (in_win)
                    begin
                        if ((ph_next == tde_pkg::PH_WAIT)
                            || ((ph_next == tde_pkg::PH_OPENREF) && (it_reg.t == open_reg)))
                        begin
                            rp_next = it_reg.price;
                            if (it_reg.t == open_reg)
                            begin
                                rt_next = open_reg;
                                ph_next = tde_pkg::PH_OPENREF;
                            end
                            else
                            begin
                                rt_next = it_reg.t;
                                ph_next = tde_pkg::PH_RUN;
                            end
                        end
                        else
                        begin
                            // a new day always takes the reference branch, so rp_reg holds here
                            ph_next = tde_pkg::PH_RUN;
                            cv_next = tde_pkg::sat_add32(cv_next, {1'b0, it_reg.volume});
                            gc_next = tde_pkg::sat_inc(gc_next);
                            if (kind_reg == tde_pkg::KIND_PRICE)
                                hit = diff >= pthr_reg;
                            else
                                hit = cv_next >= vthr_reg;
                            if (hit && (!merge_reg || (it_reg.t != rt_next)))
                            begin
                                emit_en             = 1'b1;
                                emit_row.date       = cd_next;
                                emit_row.hour       = it_reg.hour;
                                emit_row.minute     = it_reg.minute;
                                emit_row.second_ms  = it_reg.second_ms;
                                emit_row.volume     = cv_next;
                                emit_row.price      = it_reg.price;
                                emit_row.dur        = tde_pkg::dur_of(it_reg.t, rt_next);
                                emit_row.count      = gc_next;
                                emit_row.row_number = rc_reg;
                                rc_next = rc_reg + 32'd1;
                                rt_next = it_reg.t;
                                rp_next = it_reg.price;
                                cv_next = '0;
                                ts_next = '0;
                                gc_next = '0;
                            end
                        end
                    end
                end
                state_next = S_LAST;
            end
            S_LAST:
            begin
                if (it_reg.last && pend_valid_reg)
                begin
                    ret_done_next = 1'b1;
                    state_next    = S_FLUSH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                row_push        = held_valid_reg;
                row_data        = held_reg;
                row_data.last   = 1'b1;
                held_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new row pushes out the one held back; the last row waits for its flag
        if (emit_en)
        begin
            row_push        = held_valid_reg;
            row_data        = held_reg;
            held_next       = emit_row;
            held_next.last  = 1'b0;
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= tde_pkg::KIND_TRADE;
            merge_reg      <= 1'b1;
            open_reg       <= tde_pkg::OPEN_RESET;
            close_reg      <= tde_pkg::CLOSE_RESET;
            pthr_reg       <= 32'd1;
            vthr_reg       <= 32'd1;
            cd_reg         <= '0;
            ph_reg         <= tde_pkg::PH_NONE;
            rt_reg         <= '0;
            rp_reg         <= '0;
            cv_reg         <= '0;
            ts_reg         <= '0;
            gc_reg         <= '0;
            rc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            ret_done_reg   <= 1'b0;
            divcnt_reg     <= '0;
            divused_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cd_reg         <= cd_next;
            ph_reg         <= ph_next;
            rt_reg         <= rt_next;
            rp_reg         <= rp_next;
            cv_reg         <= cv_next;
            ts_reg         <= ts_next;
            gc_reg         <= gc_next;
            rc_reg         <= rc_next;
            pend_valid_reg <= pend_valid_next;
            held_valid_reg <= held_valid_next;
            ret_done_reg   <= ret_done_next;
            divcnt_reg     <= divcnt_next;
            divused_reg    <= divused_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    tde_pkg::CFG_KIND:  kind_reg  <= cfg_data[1:0];
                    tde_pkg::CFG_MERGE: merge_reg <= cfg_data[0];
                    tde_pkg::CFG_OPEN:  open_reg  <= cfg_data[26:0];
                    tde_pkg::CFG_CLOSE: close_reg <= cfg_data[26:0];
                    tde_pkg::CFG_PTHR:  pthr_reg  <= cfg_data;
                    tde_pkg::CFG_VTHR:  vthr_reg  <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg          <= it_next;
        prod_reg        <= prod_next;
        newday_reg      <= newday_next;
        joins_reg       <= joins_next;
        pend_hour_reg   <= pend_hour_next;
        pend_minute_reg <= pend_minute_next;
        pend_sec_reg    <= pend_sec_next;
        pend_t_reg      <= pend_t_next;
        pend_price_reg  <= pend_price_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        held_reg        <= held_next;
    end

    `TDE_ASSERT_IMP(a_div_nonzero, state_reg == S_DIV, cv_reg != 32'd0)
    `TDE_ASSERT_IMP(a_pend_counted, pend_valid_reg, gc_reg != 16'd0)
    `TDE_ASSERT_IMP(a_room_for_rows, item_pop, row_count <= 3'd2)
    `TDE_ASSERT_NXT(a_done_drains, state_reg == S_DONE, !held_valid_reg)

endmodule

>>> src/transaction_duration_extractor.sv
// Top level of the transaction duration extractor.
// Depends on tde_pkg, tde_front, tde_row_fifo and tde_back.
//
// Transactions enter through a queue-style port (push/full) and duration rows
// leave through another (empty/pop). The front end registers each word, packs
// date and time of day and buffers two words, so the input keeps flowing while
// the back end works. The back end takes one transaction at a time, through its
// idle, evaluate, body, last and done states; an item that closes a pending
// group also passes the flush and flush-emit states, and when that group holds
// two or more trades and a nonzero total volume, the bit-serial 64/32 divider
// forms the volume-weighted price before the emit. Up to two rows per transaction
// go into a four-word result queue; the last row of each transaction carries
// last_of_run. Config writes take effect at once and belong to idle periods.
module transaction_duration_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [11:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [15:0] second_ms,
    input  logic [30:0] volume,
    input  logic [31:0] price,
    input  logic        last_item,
    output logic        empty,
    input  logic        pop,
    output logic [11:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [4:0]  out_hour,
    output logic [5:0]  out_minute,
    output logic [15:0] out_second_ms,
    output logic [31:0] out_volume,
    output logic [31:0] out_price,
    output logic [26:0] out_duration_ms,
    output logic [15:0] out_trade_count,
    output logic [31:0] row_number,
    output logic        last_of_run,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic           item_valid;
    logic           item_pop;
    tde_pkg::item_t item;
    logic           row_push;
    tde_pkg::row_t  row_data;
    tde_pkg::row_t  head;
    logic [2:0]     row_count;

    tde_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .year       (year),
        .month      (month),
        .day        (day),
        .hour       (hour),
        .minute     (minute),
        .second_ms  (second_ms),
        .volume     (volume),
        .price      (price),
        .last_item  (last_item),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    tde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .row_push   (row_push),
        .row_data   (row_data),
        .row_count  (row_count)
    );

    tde_row_fifo u_rows (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (row_push),
        .wr_row (row_data),
        .pop    (pop),
        .empty  (empty),
        .head   (head),
        .count  (row_count)
    );

    assign out_year        = head.date[20:9];
    assign out_month       = head.date[8:5];
    assign out_day         = head.date[4:0];
    assign out_hour        = head.hour;
    assign out_minute      = head.minute;
    assign out_second_ms   = head.second_ms;
    assign out_volume      = head.volume;
    assign out_price       = head.price;
    assign out_duration_ms = head.dur;
    assign out_trade_count = head.count;
    assign row_number      = head.row_number;
    assign last_of_run     = head.last;

endmodule
